FILE: src/twrmg_pkg.sv
// twrmg_pkg: shared types and constants of the ranging filter
// no dependencies; imported by twr_range_median_gate_top and its test bench
package twrmg_pkg;

    // action codes
    localparam logic [1:0] ACT_CALC  = 2'd0;
    localparam logic [1:0] ACT_GIVEN = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SCALE  = 2'd0;
    localparam logic [1:0] CFG_OFFSET = 2'd1;
    localparam logic [1:0] CFG_GATE   = 2'd2;

    // configuration reset values
    localparam logic [23:0] SCALE_RST  = 24'd307479;
    localparam logic [15:0] OFFSET_RST = 16'd1000;
    localparam logic [15:0] GATE_RST   = 16'd500;

    // ring of raw samples
    localparam int unsigned HIST = 3;
    localparam logic [1:0] SLOT_LAST = 2'd2;

    // divider geometry: 88-bit dividend, 50-bit divisor
    localparam int unsigned DVD_W = 88;
    localparam int unsigned DIV_W = 50;
    localparam logic [6:0] DIV_LAST = 7'(DVD_W - 1);

    // one node entry in the state memory
    typedef struct packed {
        logic [HIST-1:0][15:0] hist;
        logic [1:0]            slot;
        logic [15:0]           filt;
        logic                  fresh;
    } t_entry;

    // sequencer states
    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_DIFF = 10'b00_0000_0010,
        ST_MUL1 = 10'b00_0000_0100,
        ST_MUL2 = 10'b00_0000_1000,
        ST_MAG  = 10'b00_0001_0000,
        ST_SCL1 = 10'b00_0010_0000,
        ST_SCL2 = 10'b00_0100_0000,
        ST_SUMP = 10'b00_1000_0000,
        ST_DIV  = 10'b01_0000_0000,
        ST_FIN  = 10'b10_0000_0000
    } t_state;

endpackage

FILE: src/twrmg_ram.sv
// twrmg_ram: generic single-write, single-read ram with registered read
// no dependencies
module twrmg_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/twr_range_median_gate_top.sv
// twr_range_median_gate_top: two-way ranging distance with median-of-three gate
// depends on twrmg_pkg and twrmg_ram
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_ready     | action, node, six stamps, dist
//  out     | output    | o_out_valid / i_out_ready   | node, raw, stored, flags
//  cfg     | input     | i_cfg_we (no wait)          | i_cfg_idx, i_cfg_data
//
// one transaction at a time; a ranging result passes through these steps after accept:
// six setup steps, the divisor check, 88 divide steps, a finish step and the write back
// a zero divisor skips the divide and gives its result after the divisor check
// given, query and unused actions give the result without the sequence; next accept waits for the write back
// the node memory is read at accept and written back when the result enters the out slot
// per-node valid flops make every entry read as zero after reset, no sweep
// a waiting result does not block accept; the write back waits for the out slot
module twr_range_median_gate_top #(
    parameter int unsigned NODES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_node_id,
    input  logic [31:0] i_local_poll_tx,
    input  logic [31:0] i_local_answer_rx,
    input  logic [31:0] i_local_final_tx,
    input  logic [31:0] i_remote_poll_rx,
    input  logic [31:0] i_remote_answer_tx,
    input  logic [31:0] i_remote_final_rx,
    input  logic [15:0] i_given_distance,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_node_out,
    output logic [15:0] o_raw_distance,
    output logic [15:0] o_stored_distance,
    output logic        o_updated,
    output logic        o_outlier,
    output logic        o_fresh,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);
    import twrmg_pkg::*;

    localparam int unsigned AW = $clog2(NODES);
    localparam int unsigned EW = $bits(t_entry);

    // configuration registers
    logic [23:0] r_scale;
    logic [15:0] r_offset;
    logic [15:0] r_gate;

    // sequencer and item registers
    t_state      r_state;
    logic        r_upd_pend;
    logic [1:0]  r_act;
    logic [3:0]  r_node;
    logic        r_nvalid;
    logic [AW-1:0] r_addr;
    logic [15:0] r_raw;
    logic [31:0] r_ptx, r_arx, r_ftx, r_prr, r_atr, r_frr;
    logic [31:0] r_ra, r_rb, r_da, r_db;
    logic [33:0] r_sum;
    logic [63:0] r_p1, r_p2, r_mag;
    logic        r_neg;
    logic [55:0] r_plo, r_phi;
    logic [DVD_W-1:0] r_dvd;
    logic [DIV_W-1:0] r_rem;
    logic [31:0] r_q;
    logic        r_big;
    logic [6:0]  r_cnt;

    // per-node valid bits
    logic [NODES-1:0] r_vld;

    // output register
    logic        r_ovld;
    logic [3:0]  r_onode;
    logic [15:0] r_oraw, r_ostored;
    logic        r_oupd, r_oout, r_ofr;

    logic        in_acc;
    logic        commit;
    logic [EW-1:0] rdata;
    t_entry      ent, n_ent;
    logic        mem_we;

    assign o_in_ready = (r_state == ST_IDLE) && !r_upd_pend;
    assign in_acc     = i_in_valid && o_in_ready;
    assign commit     = r_upd_pend && (!r_ovld || i_out_ready);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_RST;
            r_offset <= OFFSET_RST;
            r_gate   <= GATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALE:  r_scale  <= i_cfg_data;
                CFG_OFFSET: r_offset <= i_cfg_data[15:0];
                CFG_GATE:   r_gate   <= i_cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    // node state memory
    twrmg_ram #(.WIDTH(EW), .DEPTH(NODES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (n_ent),
        .i_re    (in_acc),
        .i_raddr (AW'(i_node_id)),
        .o_rdata (rdata)
    );

    // entry not yet written reads as zero
    assign ent = r_vld[r_addr] ? t_entry'(rdata) : '0;

    // divider step
    logic [DIV_W:0]   rem2;
    logic [DIV_W:0]   dvs;
    logic             qbit;
    logic [DIV_W:0]   rem_sub;
    always_comb begin
        rem2    = {r_rem, r_dvd[DVD_W-1]};
        dvs     = {1'b0, r_sum, 16'b0};
        qbit    = (rem2 >= dvs);
        rem_sub = qbit ? (rem2 - dvs) : rem2;
    end

    // saturation and offset of the quotient
    logic [32:0] q_c, q_v;
    logic [15:0] fin_raw;
    always_comb begin
        q_c = {1'b0, r_q} + 33'(r_rem != '0);
        q_v = {1'b0, r_q} + {17'b0, r_offset};
        if (r_neg) begin
            fin_raw = (r_big || q_c >= {17'b0, r_offset}) ? 16'd0
                    : (r_offset - q_c[15:0]);
        end else begin
            fin_raw = (r_big || q_v > 33'd65535) ? 16'hFFFF : q_v[15:0];
        end
    end

    // median of three
    function automatic logic [15:0] mid3(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] c);
        logic [15:0] m;
        if (a <= b && a <= c) m = (b <= c) ? b : c;
        else if (b <= a && b <= c) m = (a <= c) ? a : c;
        else m = (a <= b) ? a : b;
        return m;
    endfunction

    // read-modify-write of the node entry
    logic [15:0] med, diff;
    logic        samp, outl, fr;
    logic [15:0] stored;
    logic [1:0]  nslot;
    always_comb begin
        med    = mid3(ent.hist[0], ent.hist[1], ent.hist[2]);
        diff   = (med >= r_raw) ? (med - r_raw) : (r_raw - med);
        samp   = r_nvalid && (r_act == ACT_CALC || r_act == ACT_GIVEN) && (r_raw != '0);
        outl   = samp && (diff > r_gate);
        fr     = r_nvalid && (r_act == ACT_QUERY) && ent.fresh;
        nslot  = (ent.slot == SLOT_LAST) ? 2'd0 : (ent.slot + 2'd1);
        n_ent  = ent;
        mem_we = 1'b0;
        if (samp) begin
            n_ent.filt  = outl ? med : r_raw;
            n_ent.slot  = nslot;
            n_ent.hist[nslot] = r_raw;
            n_ent.fresh = 1'b1;
            mem_we      = commit;
        end else if (r_nvalid && r_act == ACT_QUERY) begin
            n_ent.fresh = 1'b0;
            mem_we      = commit;
        end
        stored = r_nvalid ? n_ent.filt : 16'd0;
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_upd_pend <= 1'b0;
            r_vld      <= '0;
            r_ovld     <= 1'b0;
        end else begin
            if (r_ovld && i_out_ready && !commit) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_act    <= i_action;
                        r_node   <= i_node_id;
                        r_nvalid <= (32'(i_node_id) < NODES);
                        r_addr   <= AW'(i_node_id);
                        r_ptx    <= i_local_poll_tx;
                        r_arx    <= i_local_answer_rx;
                        r_ftx    <= i_local_final_tx;
                        r_prr    <= i_remote_poll_rx;
                        r_atr    <= i_remote_answer_tx;
                        r_frr    <= i_remote_final_rx;
                        r_raw    <= (i_action == ACT_GIVEN) ? i_given_distance : 16'd0;
                        if (i_action == ACT_CALC) begin
                            r_state <= ST_DIFF;
                        end else begin
                            r_upd_pend <= 1'b1;
                        end
                    end
                end
                ST_DIFF: begin
                    r_ra    <= r_arx - r_ptx;
                    r_db    <= r_atr - r_prr;
                    r_rb    <= r_frr - r_atr;
                    r_da    <= r_ftx - r_arx;
                    r_state <= ST_MUL1;
                end
                ST_MUL1: begin
                    r_p1    <= {32'b0, r_ra} * {32'b0, r_rb};
                    r_sum   <= {2'b0, r_ra} + {2'b0, r_rb} + {2'b0, r_da} + {2'b0, r_db};
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_p2    <= {32'b0, r_da} * {32'b0, r_db};
                    r_state <= ST_MAG;
                end
                ST_MAG: begin
                    r_neg   <= (r_p1 < r_p2);
                    r_mag   <= (r_p1 >= r_p2) ? (r_p1 - r_p2) : (r_p2 - r_p1);
                    r_state <= ST_SCL1;
                end
                ST_SCL1: begin
                    r_plo   <= {24'b0, r_mag[31:0]} * {32'b0, r_scale};
                    r_state <= ST_SCL2;
                end
                ST_SCL2: begin
                    r_phi   <= {24'b0, r_mag[63:32]} * {32'b0, r_scale};
                    r_state <= ST_SUMP;
                end
                ST_SUMP: begin
                    r_dvd <= {r_phi, 32'b0} + {32'b0, r_plo};
                    r_rem <= '0;
                    r_q   <= '0;
                    r_big <= 1'b0;
                    r_cnt <= '0;
                    if (r_sum == '0) begin
                        r_raw      <= 16'd0;
                        r_state    <= ST_IDLE;
                        r_upd_pend <= 1'b1;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem <= rem_sub[DIV_W-1:0];
                    r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                    r_big <= r_big | r_q[31];
                    r_q   <= {r_q[30:0], qbit};
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_raw      <= fin_raw;
                    r_state    <= ST_IDLE;
                    r_upd_pend <= 1'b1;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // write back and present the result
            if (commit) begin
                r_upd_pend <= 1'b0;
                r_ovld     <= 1'b1;
                if (mem_we) begin
                    r_vld[r_addr] <= 1'b1;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_onode   <= r_node;
            r_oraw    <= r_raw;
            r_ostored <= stored;
            r_oupd    <= samp;
            r_oout    <= outl;
            r_ofr     <= fr;
        end
    end

    assign o_out_valid       = r_ovld;
    assign o_node_out        = r_onode;
    assign o_raw_distance    = r_oraw;
    assign o_stored_distance = r_ostored;
    assign o_updated         = r_oupd;
    assign o_outlier         = r_oout;
    assign o_fresh           = r_ofr;

    // checks
    a_outl_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_outlier |-> o_updated)
        else $error("outlier flagged without update");
    a_fresh_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fresh |-> !o_updated)
        else $error("fresh flagged on a sample transaction");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("second transaction taken while one is in flight");
    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upd_pend |-> r_state == ST_IDLE)
        else $error("write back pending while sequencer busy");
endmodule

FILE: tb/twr_range_median_gate_top_test.sv
// twr_range_median_gate_top_test: self-checking bench for the ranging filter
// depends on twrmg_pkg and twr_range_median_gate_top; directed table, then random exchanges
`timescale 1ns / 1ps
module twr_range_median_gate_top_test;
    import twrmg_pkg::*;

    localparam int unsigned NODE_CNT = 16;
    localparam int unsigned STALL_LIMIT = 3000;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  node;
        logic [31:0] ptx, arx, ftx, prr, atr, frr;
        logic [15:0] given;
    } t_ranging_req;

    typedef struct packed {
        logic [3:0]  node;
        logic [15:0] raw;
        logic [15:0] stored;
        logic        upd;
        logic        outl;
        logic        fr;
    } t_ranging_res;

    typedef struct packed {
        t_ranging_req req;
        logic         typed;
        t_ranging_res res;
    } t_table_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_action;
    logic [3:0]  i_node_id;
    logic [31:0] i_local_poll_tx, i_local_answer_rx, i_local_final_tx;
    logic [31:0] i_remote_poll_rx, i_remote_answer_tx, i_remote_final_rx;
    logic [15:0] i_given_distance;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [3:0]  o_node_out;
    logic [15:0] o_raw_distance, o_stored_distance;
    logic        o_updated, o_outlier, o_fresh;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;

    twr_range_median_gate_top #(.NODES(NODE_CNT)) i_dut (.*);

    // shadow of the block's configuration and node state
    logic [23:0] scale_q16;
    logic [15:0] offset_val, gate_val;
    logic [15:0] hist_mem [NODE_CNT][3];
    logic [1:0]  slot_mem [NODE_CNT];
    logic [15:0] filt_mem [NODE_CNT];
    logic        fresh_mem [NODE_CNT];

    t_ranging_res expected_results[$];
    int  error_count;
    int  idle_cycles;
    bit  calm_tx, calm_rx;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // median of three samples
    function automatic logic [15:0] median3(input logic [15:0] a, b, c);
        if (a <= b && a <= c) return (b <= c) ? b : c;
        if (b <= a && b <= c) return (a <= c) ? a : c;
        return (a <= b) ? a : b;
    endfunction

    // asymmetric double-sided distance, exact floor, saturated to 16 bits
    function automatic logic [15:0] ranging_mm(input t_ranging_req rq);
        logic [31:0] ra, db, rb, da;
        logic [33:0] sum;
        logic [63:0] p1, p2, mag;
        logic        neg;
        logic [87:0] prod, dv, q, r, acc;
        ra = rq.arx - rq.ptx;
        db = rq.atr - rq.prr;
        rb = rq.frr - rq.atr;
        da = rq.ftx - rq.arx;
        sum = 34'(ra) + 34'(rb) + 34'(da) + 34'(db);
        if (sum == 0) return 16'd0;
        p1 = 64'(ra) * 64'(rb);
        p2 = 64'(da) * 64'(db);
        neg = p1 < p2;
        mag = neg ? p2 - p1 : p1 - p2;
        prod = 88'(mag) * 88'(scale_q16);
        dv = 88'(sum) << 16;
        q = prod / dv;
        r = prod % dv;
        if (!neg) begin
            acc = q + 88'(offset_val);
            return (acc > 88'd65535) ? 16'hFFFF : acc[15:0];
        end
        acc = q + ((r != 0) ? 88'd1 : 88'd0);
        return (acc >= 88'(offset_val)) ? 16'd0 : 16'(88'(offset_val) - acc);
    endfunction

    // expected result of one transaction, updating the shadow state
    function automatic t_ranging_res filter_step(input t_ranging_req rq);
        t_ranging_res rs;
        logic [15:0]  med, diff;
        logic [1:0]   sl;
        rs = '0;
        rs.node = rq.node;
        if (rq.action == ACT_CALC) rs.raw = ranging_mm(rq);
        else if (rq.action == ACT_GIVEN) rs.raw = rq.given;
        if ((rq.action == ACT_CALC || rq.action == ACT_GIVEN) && rs.raw != 0) begin
            med = median3(hist_mem[rq.node][0], hist_mem[rq.node][1], hist_mem[rq.node][2]);
            diff = (med >= rs.raw) ? med - rs.raw : rs.raw - med;
            if (diff > gate_val) begin
                filt_mem[rq.node] = med;
                rs.outl = 1'b1;
            end else begin
                filt_mem[rq.node] = rs.raw;
            end
            sl = (slot_mem[rq.node] == SLOT_LAST) ? 2'd0 : slot_mem[rq.node] + 2'd1;
            slot_mem[rq.node] = sl;
            hist_mem[rq.node][sl] = rs.raw;
            fresh_mem[rq.node] = 1'b1;
            rs.upd = 1'b1;
        end else if (rq.action == ACT_QUERY) begin
            rs.fr = fresh_mem[rq.node];
            fresh_mem[rq.node] = 1'b0;
        end
        rs.stored = filt_mem[rq.node];
        return rs;
    endfunction

    // one input transaction with a random lead-in gap
    task automatic send_request(input t_ranging_req rq, input logic typed,
                                input t_ranging_res typed_res);
        int gap;
        t_ranging_res rs;
        gap = calm_tx ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_action           <= rq.action;
        i_node_id          <= rq.node;
        i_local_poll_tx    <= rq.ptx;
        i_local_answer_rx  <= rq.arx;
        i_local_final_tx   <= rq.ftx;
        i_remote_poll_rx   <= rq.prr;
        i_remote_answer_tx <= rq.atr;
        i_remote_final_rx  <= rq.frr;
        i_given_distance   <= rq.given;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        rs = filter_step(rq);
        if (typed) rs = typed_res;
        expected_results.push_back(rs);
    endtask

    // register writes once the block has drained
    task automatic write_config(input logic [23:0] sc, input logic [15:0] ofs,
                                input logic [15:0] gt);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_SCALE;
        i_cfg_data <= sc;
        @(posedge i_clk);
        i_cfg_idx <= CFG_OFFSET;
        i_cfg_data <= 24'(ofs);
        @(posedge i_clk);
        i_cfg_idx <= CFG_GATE;
        i_cfg_data <= 24'(gt);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        scale_q16 = sc;
        offset_val = ofs;
        gate_val = gt;
    endtask

    // random transaction: mostly plausible exchanges, some noise
    function automatic t_ranging_req random_request();
        t_ranging_req rq;
        logic [31:0]  tof, rep_a, rep_b, roff;
        int           pick;
        rq = '0;
        rq.node = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        tof = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20000) : $urandom_range(0, 1500);
        rep_a = $urandom_range(0, 4194304);
        rep_b = $urandom_range(0, 4194304);
        roff = $urandom;
        rq.ptx = $urandom;
        rq.prr = rq.ptx + tof + roff;
        rq.atr = rq.prr + rep_b;
        rq.arx = rq.atr - roff + tof;
        rq.ftx = rq.arx + rep_a;
        rq.frr = rq.ftx + roff + tof;
        rq.given = 16'($urandom);
        if (pick < 55) begin
            rq.action = ACT_CALC;
            if ($urandom_range(0, 4) == 0) rq.arx = rq.arx + $urandom_range(0, 600);
        end else if (pick < 75) begin
            rq.action = ACT_GIVEN;
            if ($urandom_range(0, 2) != 0)
                rq.given = filt_mem[rq.node] + 16'($urandom_range(0, 1200)) - 16'd600;
            else if ($urandom_range(0, 9) == 0)
                rq.given = 16'd0;
        end else if (pick < 88) begin
            rq.action = ACT_QUERY;
        end else if (pick < 95) begin
            rq.action = ACT_CALC;
            {rq.ptx, rq.arx, rq.ftx} = {$urandom, $urandom, $urandom};
            {rq.prr, rq.atr, rq.frr} = {$urandom, $urandom, $urandom};
        end else begin
            rq.action = 2'd3;
        end
        return rq;
    endfunction

    // directed rows
    function automatic t_table_row make_row(input logic [1:0] act, input logic [3:0] nd,
                                            input logic [31:0] a0, a1, a2, b0, b1, b2,
                                            input logic [15:0] gv, input logic typed,
                                            input t_ranging_res rs);
        t_table_row row;
        row.req = '{act, nd, a0, a1, a2, b0, b1, b2, gv};
        row.typed = typed;
        row.res = rs;
        return row;
    endfunction

    // stimulus
    initial begin
        t_table_row   dir_rows[$];
        t_ranging_res none;
        none = '0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_action = ACT_CALC;
        i_node_id = '0;
        {i_local_poll_tx, i_local_answer_rx, i_local_final_tx} = '0;
        {i_remote_poll_rx, i_remote_answer_tx, i_remote_final_rx} = '0;
        i_given_distance = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SCALE;
        i_cfg_data = '0;
        calm_tx = 1'b0;
        scale_q16 = SCALE_RST;
        offset_val = OFFSET_RST;
        gate_val = GATE_RST;
        for (int n = 0; n < NODE_CNT; n++) begin
            hist_mem[n] = '{16'd0, 16'd0, 16'd0};
            slot_mem[n] = 2'd0;
            filt_mem[n] = 16'd0;
            fresh_mem[n] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // query after reset, zero divisor, zero sample, outlier, fresh mark, unused action
        dir_rows.push_back(make_row(ACT_QUERY, 4'd0, 0, 0, 0, 0, 0, 0, 0, 1, none));
        dir_rows.push_back(make_row(ACT_CALC, 4'd0, 0, 0, 0, 0, 0, 0, 0, 1, none));
        dir_rows.push_back(make_row(ACT_GIVEN, 4'd2, 0, 0, 0, 0, 0, 0, 16'd0, 1,
                                    '{4'd2, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0}));
        dir_rows.push_back(make_row(ACT_GIVEN, 4'd1, 0, 0, 0, 0, 0, 0, 16'hFFFF, 1,
                                    '{4'd1, 16'hFFFF, 16'd0, 1'b1, 1'b1, 1'b0}));
        dir_rows.push_back(make_row(ACT_QUERY, 4'd1, 0, 0, 0, 0, 0, 0, 0, 1,
                                    '{4'd1, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1}));
        dir_rows.push_back(make_row(ACT_QUERY, 4'd1, 0, 0, 0, 0, 0, 0, 0, 1,
                                    '{4'd1, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0}));
        dir_rows.push_back(make_row(2'd3, 4'd1, '1, '1, '1, '1, '1, '1, 16'hFFFF, 1,
                                    '{4'd1, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0}));
        dir_rows.push_back(make_row(ACT_GIVEN, 4'd15, 0, 0, 0, 0, 0, 0, 16'd300, 1,
                                    '{4'd15, 16'd300, 16'd300, 1'b1, 1'b0, 1'b0}));
        // ring wrap on one node
        dir_rows.push_back(make_row(ACT_GIVEN, 4'd15, 0, 0, 0, 0, 0, 0, 16'd400, 0, none));
        dir_rows.push_back(make_row(ACT_GIVEN, 4'd15, 0, 0, 0, 0, 0, 0, 16'd5000, 0, none));
        dir_rows.push_back(make_row(ACT_GIVEN, 4'd15, 0, 0, 0, 0, 0, 0, 16'd5100, 0, none));
        dir_rows.push_back(make_row(ACT_GIVEN, 4'd15, 0, 0, 0, 0, 0, 0, 16'd5200, 0, none));
        dir_rows.push_back(make_row(ACT_QUERY, 4'd15, 0, 0, 0, 0, 0, 0, 0, 0, none));
        // plausible exchange, wrapped stamps, negative numerator, saturation
        dir_rows.push_back(make_row(ACT_CALC, 4'd3, 32'd1000, 32'd201400, 32'd401000,
                                    32'd5000, 32'd105000, 32'd305400, 0, 0, none));
        dir_rows.push_back(make_row(ACT_CALC, 4'd3, 32'hFFFF_FF00, 32'h0003_0F00,
                                    32'h0006_1000, 32'hFFFF_FFF0, 32'h0001_8000,
                                    32'h0004_9200, 0, 0, none));
        dir_rows.push_back(make_row(ACT_CALC, 4'd4, 32'd0, 32'd10, 32'hFFFF_0000,
                                    32'd0, 32'hFFFF_0000, 32'hFFFF_0005, 0, 0, none));
        dir_rows.push_back(make_row(ACT_CALC, 4'd5, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'd0, 32'd0, 32'hFFFF_FFFF, 0, 0, none));
        foreach (dir_rows[k]) send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);

        // random phases across register settings: reset values, then extremes, then random values
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1: write_config(24'hFFFFFF, 16'd0, 16'd0);
                2: write_config(24'd0, 16'hFFFF, 16'hFFFF);
                3: write_config(24'($urandom_range(200000, 400000)),
                                16'($urandom_range(0, 3000)), 16'($urandom_range(0, 2000)));
                default: ;
            endcase
            for (int k = 0; k < 270; k++) begin
                if (k % 90 == 0) calm_tx = ($urandom_range(0, 2) == 0);
                send_request(random_request(), 1'b0, none);
            end
        end
        i_in_valid <= 1'b0;

        // drain
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (error_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    // result side backpressure
    initial begin
        int stall;
        calm_rx = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 49) == 0) calm_rx = ~calm_rx;
            stall = calm_rx ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_ranging_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result node %0d raw %0d", $time,
                         o_node_out, o_raw_distance);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_node_out !== want.node ||
                    o_raw_distance !== want.raw ||
                    o_stored_distance !== want.stored ||
                    o_updated !== want.upd || o_outlier !== want.outl ||
                    o_fresh !== want.fr) begin
                    $display("%0t: mismatch expected node %0d raw %0d stored %0d upd %0b outl %0b fresh %0b",
                             $time, want.node, want.raw, want.stored, want.upd, want.outl,
                             want.fr);
                    $display("%0t:          actual node %0d raw %0d stored %0d upd %0b outl %0b fresh %0b",
                             $time, o_node_out, o_raw_distance, o_stored_distance,
                             o_updated, o_outlier, o_fresh);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("Verification failed");
            $finish;
        end
    end

endmodule

FILE: filelist.f
src/twrmg_pkg.sv
src/twrmg_ram.sv
src/twr_range_median_gate_top.sv
tb/twr_range_median_gate_top_test.sv
